>>> src/icy_metadata_deframer_core_assert.svh
// ----------------------------------------------------------------------------
// icy_metadata_deframer_core assertion macros
// Concurrent assertion helpers shared by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ICY_METADATA_DEFRAMER_CORE_ASSERT_SVH
`define ICY_METADATA_DEFRAMER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ICY_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ICY_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/icy_pkg.sv
// ----------------------------------------------------------------------------
// icy_pkg
// Shared types and constants for the ICY metadata deframer.
// ----------------------------------------------------------------------------
package icy_pkg;

   localparam int BYTE_W     = 8;
   localparam int KIND_W     = 2;
   localparam int INTERVAL_W = 20;
   localparam int REMAIN_W   = 12;
   localparam int COUNT_W    = 32;
   localparam int UNIT_SHIFT = 4;   // length byte counts blocks of 16 bytes
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_AUDIO = 2'd0,
      KIND_LEN   = 2'd1,
      KIND_META  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_AUDIO = 2'd0,
      PHASE_META  = 2'd1
   } phase_type;

   typedef enum logic {
      REG_META_INTERVAL = 1'b0
   } reg_index_type;

   typedef struct packed {
      kind_type             kind;
      logic                 last;
      logic [COUNT_W-1:0]   audio_position;
   } step_result_type;

endpackage

>>> src/icy_csr.sv
// ----------------------------------------------------------------------------
// icy_csr
// APB-style register file holding the metadata interval.
// ----------------------------------------------------------------------------
module icy_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [icy_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [icy_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [icy_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready,
   output logic [icy_pkg::INTERVAL_W-1:0]      meta_interval
);

   logic [icy_pkg::INTERVAL_W-1:0] interval_ff;
   logic [icy_pkg::INTERVAL_W-1:0] interval_in;
   icy_pkg::reg_index_type         index;
   logic                           write_en;

   assign index    = icy_pkg::reg_index_type'(paddr[icy_pkg::CSR_ADDR_W-1]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;

   always_comb begin
      interval_in = interval_ff;
      if (write_en && index == icy_pkg::REG_META_INTERVAL) begin
         interval_in = pwdata[icy_pkg::INTERVAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= '0;
      end else begin
         interval_ff <= interval_in;
      end
   end

   always_comb begin
      unique case (index)
         icy_pkg::REG_META_INTERVAL:
            prdata = {{(icy_pkg::CSR_DATA_W-icy_pkg::INTERVAL_W){1'b0}}, interval_ff};
         default: prdata = '0;
      endcase
   end

   assign meta_interval = interval_ff;

endmodule

>>> src/icy_deframe.sv
// ----------------------------------------------------------------------------
// icy_deframe
// Deframer state and per-byte classification step.
// ----------------------------------------------------------------------------
module icy_deframe (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step_en,
   input  logic [icy_pkg::BYTE_W-1:0]        data_byte,
   input  logic [icy_pkg::INTERVAL_W-1:0]    meta_interval,
   output icy_pkg::step_result_type          result
);

   icy_pkg::phase_type              phase_ff, phase_in;
   logic [icy_pkg::INTERVAL_W-1:0]  icount_ff, icount_in;
   logic [icy_pkg::REMAIN_W-1:0]    remain_ff, remain_in;
   logic [icy_pkg::COUNT_W-1:0]     acount_ff, acount_in;
   logic [icy_pkg::REMAIN_W-1:0]    remain_dec;
   logic [icy_pkg::REMAIN_W-1:0]    block_len;

   assign remain_dec = (remain_ff != '0) ? remain_ff - 1'b1 : '0;
   assign block_len  = {data_byte, {icy_pkg::UNIT_SHIFT{1'b0}}};

   always_comb begin
      phase_in    = phase_ff;
      icount_in   = icount_ff;
      remain_in   = remain_ff;
      acount_in   = acount_ff;
      result.kind = icy_pkg::KIND_AUDIO;
      result.last = 1'b0;
      if (meta_interval == '0) begin
         phase_in  = icy_pkg::PHASE_AUDIO;
         icount_in = '0;
         remain_in = '0;
         acount_in = acount_ff + 1'b1;
      end else if (phase_ff == icy_pkg::PHASE_META) begin
         result.kind = icy_pkg::KIND_META;
         remain_in   = remain_dec;
         if (remain_dec == '0) begin
            result.last = 1'b1;
            phase_in    = icy_pkg::PHASE_AUDIO;
            icount_in   = '0;
         end
      end else if (icount_ff >= meta_interval) begin
         result.kind = icy_pkg::KIND_LEN;
         remain_in   = block_len;
         icount_in   = '0;
         if (block_len == '0) begin
            result.last = 1'b1;
            phase_in    = icy_pkg::PHASE_AUDIO;
         end else begin
            phase_in    = icy_pkg::PHASE_META;
         end
      end else begin
         phase_in  = icy_pkg::PHASE_AUDIO;
         icount_in = icount_ff + 1'b1;
         acount_in = acount_ff + 1'b1;
      end
      result.audio_position = acount_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= icy_pkg::PHASE_AUDIO;
         icount_ff <= '0;
         remain_ff <= '0;
         acount_ff <= '0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         icount_ff <= icount_in;
         remain_ff <= remain_in;
         acount_ff <= acount_in;
      end
   end

endmodule

>>> src/icy_metadata_deframer_core.sv
// ----------------------------------------------------------------------------
// icy_metadata_deframer_core
// Splits an ICY stream body into audio, metadata length and metadata bytes.
// ----------------------------------------------------------------------------
// Takes one byte per clock while not stalled and returns one result per byte.
// The byte goes to an input register, the classification step (one compare
// of the interval count and the counter updates) runs between that register
// and the result register, so a full byte per cycle is sustained whenever
// the result side is not stalled. Write meta_interval (register 0, byte
// address 0) only while no bytes are in flight.
module icy_metadata_deframer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [icy_pkg::BYTE_W-1:0]        req_data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [icy_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic [icy_pkg::KIND_W-1:0]        rsp_byte_kind,
   output logic                              rsp_meta_last,
   output logic [icy_pkg::COUNT_W-1:0]       rsp_audio_position,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [icy_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [icy_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [icy_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

`include "icy_metadata_deframer_core_assert.svh"

   logic [icy_pkg::INTERVAL_W-1:0]  meta_interval;
   logic                            in_valid_ff, in_valid_in;
   logic [icy_pkg::BYTE_W-1:0]      in_byte_ff;
   logic                            out_valid_ff, out_valid_in;
   logic [icy_pkg::BYTE_W-1:0]      out_byte_ff;
   icy_pkg::step_result_type        out_result_ff;
   icy_pkg::step_result_type        step_result;
   logic                            out_open;
   logic                            step_en;
   logic                            in_load;

   icy_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (csr_psel),
      .penable       (csr_penable),
      .pwrite        (csr_pwrite),
      .paddr         (csr_paddr),
      .pwdata        (csr_pwdata),
      .prdata        (csr_prdata),
      .pready        (csr_pready),
      .meta_interval (meta_interval)
   );

   icy_deframe u_deframe (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step_en),
      .data_byte     (in_byte_ff),
      .meta_interval (meta_interval),
      .result        (step_result)
   );

   assign out_open  = !out_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && out_open;
   assign req_stall = in_valid_ff && !out_open;
   assign in_load   = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = in_load || (in_valid_ff && !step_en);
      out_valid_in = step_en || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_byte_ff <= req_data_byte;
      end
      if (step_en) begin
         out_byte_ff   <= in_byte_ff;
         out_result_ff <= step_result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_byte_kind      = out_result_ff.kind;
   assign rsp_meta_last      = out_result_ff.last;
   assign rsp_audio_position = out_result_ff.audio_position;

   `ICY_ASSERT_SAME(a_kind_legal, clock, reset, rsp_valid, rsp_byte_kind != 2'd3)
   `ICY_ASSERT_SAME(a_last_not_audio, clock, reset, rsp_valid && rsp_meta_last, rsp_byte_kind != icy_pkg::KIND_AUDIO)
   `ICY_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !step_en, in_valid_ff && $stable(in_byte_ff))

endmodule
